// ===== rtl/cdc_pkg.sv =====
// types, codes and month table shared by the calendar date counter
package cdc_pkg;

    localparam int YEAR_W   = 14;
    localparam int MONTH_W  = 4;
    localparam int DAY_W    = 5;
    localparam int COUNT_W  = 16;
    localparam int PACKED_W = 27;
    localparam int STATUS_W = 2;

    localparam logic [YEAR_W-1:0]  RESET_YEAR  = 14'd2000;
    localparam logic [MONTH_W-1:0] RESET_MONTH = 4'd1;
    localparam logic [DAY_W-1:0]   RESET_DAY   = 5'd1;
    localparam logic [MONTH_W-1:0] LAST_MONTH  = 4'd12;

    localparam logic REQ_SET     = 1'b0;
    localparam logic REQ_ADVANCE = 1'b1;

    localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] ST_BAD_MONTH = 2'd1;
    localparam logic [STATUS_W-1:0] ST_BAD_DAY   = 2'd2;

    typedef struct packed {
        logic                req_type;
        logic [YEAR_W-1:0]   new_year;
        logic [MONTH_W-1:0]  new_month;
        logic [DAY_W-1:0]    new_day;
        logic [COUNT_W-1:0]  day_count;
    } req_t;

    typedef struct packed {
        logic [YEAR_W-1:0]   cur_year;
        logic [MONTH_W-1:0]  cur_month;
        logic [DAY_W-1:0]    cur_day;
        logic [PACKED_W-1:0] packed_date;
        logic [STATUS_W-1:0] status;
    } rsp_t;

    typedef struct packed {
        logic [YEAR_W-1:0]   year;
        logic [MONTH_W-1:0]  month;
        logic [DAY_W-1:0]    day;
    } date_t;

    // month length, february follows the leap flag; out-of-range months read as 31
    function automatic logic [DAY_W-1:0] days_in(input logic leap, input logic [MONTH_W-1:0] m);
        logic [DAY_W-1:0] len;
        begin
            case (m)
                4'd1:    len = 5'd31;
                4'd2:    len = leap ? 5'd29 : 5'd28;
                4'd3:    len = 5'd31;
                4'd4:    len = 5'd30;
                4'd5:    len = 5'd31;
                4'd6:    len = 5'd30;
                4'd7:    len = 5'd31;
                4'd8:    len = 5'd31;
                4'd9:    len = 5'd30;
                4'd10:   len = 5'd31;
                4'd11:   len = 5'd30;
                4'd12:   len = 5'd31;
                default: len = 5'd31;
            endcase
            days_in = len;
        end
    endfunction

endpackage

// ===== rtl/cdc_leap.sv =====
// leap year unit: registers the leap flag of the year presented on load
module cdc_leap
    import cdc_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              load,
    input  logic [YEAR_W-1:0] year,
    output logic              leap
);

    // reciprocal of 25 scaled by 2^17, exact quotient for any 14-bit year
    localparam logic [12:0] RECIP25 = 13'd5243;

    logic [26:0]       prod;
    logic [9:0]        quot;
    logic [YEAR_W-1:0] quot25;
    logic              div25;
    logic              leap_reg;
    logic              leap_next;

    assign prod   = 27'(year) * 27'(RECIP25);
    assign quot   = prod[26:17];
    assign quot25 = YEAR_W'({quot, 4'b0000}) + YEAR_W'({quot, 3'b000}) + YEAR_W'(quot);
    assign div25  = (year == quot25);

    // divisible by 4, and either not by 100 or also by 400
    assign leap_next = (year[1:0] == 2'b00) && (!div25 || (year[3:0] == 4'b0000));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            leap_reg <= 1'b0;
        end
        else if (load)
        begin
            leap_reg <= leap_next;
        end
    end

    assign leap = leap_reg;

endmodule

// ===== rtl/cdc_result.sv =====
// result register: packs the date and holds the item until it is taken
module cdc_result
    import cdc_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                load,
    input  date_t               date,
    input  logic [STATUS_W-1:0] status,
    output logic                free,
    output logic                rsp_valid,
    input  logic                rsp_stall,
    output rsp_t                rsp
);

    localparam logic [YEAR_W-1:0] YEAR_SCALE = 14'd10000;

    logic          valid_reg;
    rsp_t          rsp_reg;
    rsp_t          rsp_next;
    logic [27:0]   year_part;
    logic [10:0]   month_part;

    assign year_part  = 28'(date.year) * 28'(YEAR_SCALE);
    assign month_part = 11'({date.month, 6'b000000}) + 11'({date.month, 5'b00000})
                      + 11'({date.month, 2'b00});

    always_comb
    begin
        rsp_next.cur_year    = date.year;
        rsp_next.cur_month   = date.month;
        rsp_next.cur_day     = date.day;
        rsp_next.packed_date = year_part[PACKED_W-1:0] + PACKED_W'(month_part)
                             + PACKED_W'(date.day);
        rsp_next.status      = status;
    end

    assign free = !valid_reg || !rsp_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (free)
        begin
            valid_reg <= load;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load && free)
        begin
            rsp_reg <= rsp_next;
        end
    end

    assign rsp_valid = valid_reg;
    assign rsp       = rsp_reg;

endmodule

// ===== rtl/calendar_date_counter.sv =====
// calendar date counter: set with validity check, or advance by a day count
// set item: the sequencer steps through set-leap, set-check and done; the result is
// registered as done hands back to idle, which then takes the next item; advance item:
// a leap step, then one day a cycle, with a leap step again at each year boundary crossed
// a stalled result holds the sequencer in its done state, and the input stalls meanwhile
// reset: date 2000-01-01, no result pending, ready for an item.
module calendar_date_counter
    import cdc_pkg::*;
#(
    parameter int YEAR_MAX    = 9999,
    parameter int COUNT_WIDTH = 16
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic req_valid,
    output logic req_stall,
    input  req_t req,
    output logic rsp_valid,
    input  logic rsp_stall,
    output rsp_t rsp
);

    localparam int CNT_W = (COUNT_WIDTH < COUNT_W) ? COUNT_WIDTH : COUNT_W;
    localparam logic [YEAR_W-1:0] YMAX = YEAR_MAX[YEAR_W-1:0];

    typedef enum logic [2:0] {
        S_IDLE,
        S_SET_LEAP,
        S_SET_CHECK,
        S_ADV_LEAP,
        S_ADV_STEP,
        S_DONE
    } state_t;

    state_t              state_reg;
    date_t               date_reg;
    date_t               op_reg;
    logic [CNT_W-1:0]    count_reg;
    logic [STATUS_W-1:0] status_reg;

    logic                leap;
    logic                leap_load;
    logic [YEAR_W-1:0]   leap_year;
    logic                res_free;
    logic                res_load;
    logic [YEAR_W-1:0]   sat_year;
    logic [DAY_W-1:0]    set_len;
    logic [DAY_W-1:0]    cur_len;

    assign sat_year  = (req.new_year > YMAX) ? YMAX : req.new_year;
    assign leap_load = (state_reg == S_SET_LEAP) || (state_reg == S_ADV_LEAP);
    assign leap_year = (state_reg == S_SET_LEAP) ? op_reg.year : date_reg.year;
    assign set_len   = days_in(leap, op_reg.month);
    assign cur_len   = days_in(leap, date_reg.month);
    assign res_load  = (state_reg == S_DONE);
    assign req_stall = (state_reg != S_IDLE);

    cdc_leap u_leap (
        .clk   (clk),
        .rst_n (rst_n),
        .load  (leap_load),
        .year  (leap_year),
        .leap  (leap)
    );

    cdc_result u_result (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (res_load),
        .date      (date_reg),
        .status    (status_reg),
        .free      (res_free),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            date_reg.year  <= RESET_YEAR;
            date_reg.month <= RESET_MONTH;
            date_reg.day   <= RESET_DAY;
            status_reg     <= ST_OK;
            op_reg         <= '0;
            count_reg      <= '0;
        end
        else
        begin
            case (state_reg)
                S_IDLE:
                begin
                    if (req_valid)
                    begin
                        op_reg.year  <= sat_year;
                        op_reg.month <= req.new_month;
                        op_reg.day   <= req.new_day;
                        count_reg    <= req.day_count[CNT_W-1:0];
                        status_reg   <= ST_OK;
                        state_reg    <= (req.req_type == REQ_ADVANCE) ? S_ADV_LEAP
                                                                     : S_SET_LEAP;
                    end
                end
                S_SET_LEAP:
                begin
                    state_reg <= S_SET_CHECK;
                end
                S_SET_CHECK:
                begin
                    // month is checked before day
                    if (op_reg.month == '0 || op_reg.month > LAST_MONTH)
                    begin
                        status_reg <= ST_BAD_MONTH;
                    end
                    else if (op_reg.day == '0 || op_reg.day > set_len)
                    begin
                        status_reg <= ST_BAD_DAY;
                    end
                    else
                    begin
                        date_reg <= op_reg;
                    end
                    state_reg <= S_DONE;
                end
                S_ADV_LEAP:
                begin
                    state_reg <= S_ADV_STEP;
                end
                S_ADV_STEP:
                begin
                    if (count_reg == '0)
                    begin
                        state_reg <= S_DONE;
                    end
                    else
                    begin
                        count_reg <= count_reg - CNT_W'(1);
                        if (date_reg.day < cur_len)
                        begin
                            date_reg.day <= date_reg.day + DAY_W'(1);
                        end
                        else if (date_reg.month < LAST_MONTH)
                        begin
                            date_reg.month <= date_reg.month + MONTH_W'(1);
                            date_reg.day   <= RESET_DAY;
                        end
                        else
                        begin
                            // new year: refresh the leap flag before the next step
                            date_reg.year  <= (date_reg.year >= YMAX) ? '0
                                            : date_reg.year + YEAR_W'(1);
                            date_reg.month <= RESET_MONTH;
                            date_reg.day   <= RESET_DAY;
                            state_reg      <= S_ADV_LEAP;
                        end
                    end
                end
                S_DONE:
                begin
                    if (res_free)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule
